// ----- rtl/dtdc_pkg.sv -----
// Shared widths, constants, error codes and calendar tables for the date to day-count block.
// No dependencies. Used by dtdc_split, dtdc_count and date_to_day_count.
package dtdc_pkg;

   // Field widths
   localparam int DateW  = 27;
   localparam int CountW = 22;
   localparam int ErrW   = 3;
   localparam int YearW  = 14;
   localparam int QuotW  = 14;
   localparam int DayW   = 8;
   localparam int MonthW = 7;
   localparam int CentW  = 7;
   localparam int MdayW  = 10;

   // Error codes
   localparam logic [ErrW-1:0] ERR_OK    = 3'd0;
   localparam logic [ErrW-1:0] ERR_ZERO  = 3'd1;
   localparam logic [ErrW-1:0] ERR_YEAR  = 3'd2;
   localparam logic [ErrW-1:0] ERR_MONTH = 3'd3;
   localparam logic [ErrW-1:0] ERR_DAY   = 3'd4;

   // Reciprocals: floor(v*M >> S) is exact over the whole operand range
   localparam int RecipW10k              = 28;
   localparam logic [RecipW10k-1:0] RECIP_10K = 28'd219902326;
   localparam int Shift10k               = 41;
   localparam int RecipW100              = 15;
   localparam logic [RecipW100-1:0] RECIP_100 = 15'd20972;
   localparam int Shift100               = 21;

   localparam int Prod10kW = DateW + RecipW10k;   // 55
   localparam int Prod100W = QuotW + RecipW100;   // 29

   localparam int DaysPerYear = 365;
   localparam int DaysPer10k  = 10000;
   localparam int MonthsMax   = 12;

   // Data carried from the decimal split into the day-count stages
   typedef struct packed {
      logic              zero;
      logic              year_zero;
      logic [MonthW-1:0] month;
      logic [DayW-1:0]   day;
      logic [YearW-1:0]  y;          // year - 1
      logic [CentW-1:0]  cent_y;     // (year - 1) / 100
      logic [CentW-1:0]  cent_year;  // year / 100
      logic [CountW-1:0] y365;       // 365 * (year - 1)
   } dtdc_split_type;

   // Length of a month; 0 for a month code that is not a month
   function automatic logic [4:0] month_len_fn(input logic [MonthW-1:0] month,
                                                input logic leap);
      logic [4:0] len;
      begin
         unique case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
         endcase
         return len;
      end
   endfunction

   // Days before the first of a month in a common year
   function automatic logic [8:0] days_before_fn(input logic [MonthW-1:0] month);
      logic [8:0] d;
      begin
         unique case (month)
            7'd1:    d = 9'd0;
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
         endcase
         return d;
      end
   endfunction

endpackage

// ----- rtl/dtdc_split.sv -----
// Three-stage decimal split of a packed ddmmyyyy date into day, month and year terms.
// Depends on dtdc_pkg. Instantiated by date_to_day_count.
module dtdc_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  logic [dtdc_pkg::DateW-1:0]  in_date,
   output logic                        out_valid,
   input  logic                        out_stall,
   output dtdc_pkg::dtdc_split_type    out_data
);
   import dtdc_pkg::*;

   // Stage 1 registers
   logic                     s1_valid_ff, s1_valid_in;
   logic [DateW-1:0]         s1_date_ff;
   logic [QuotW-1:0]         s1_quot_ff, s1_quot_in;
   // Stage 2 registers
   logic                     s2_valid_ff, s2_valid_in;
   logic                     s2_zero_ff, s2_zero_in;
   logic [YearW-1:0]         s2_year_ff, s2_year_in;
   logic [QuotW-1:0]         s2_quot_ff;
   logic [DayW-1:0]          s2_day_ff, s2_day_in;
   // Stage 3 registers
   logic                     s3_valid_ff, s3_valid_in;
   dtdc_split_type           s3_data_ff, s3_data_in;

   logic                     s1_en, s2_en, s3_en;
   logic [Prod10kW-1:0]      prod_10k;
   logic [27:0]              quot_x10k;
   logic [Prod100W-1:0]      prod_day;
   logic [QuotW:0]           day_x100;
   logic [YearW-1:0]         y_s3;
   logic [Prod100W-1:0]      prod_cent_y, prod_cent_year;

   // Stage enables: a stage loads when empty or when its successor moves
   assign s3_en     = !s3_valid_ff || !out_stall;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign in_stall  = !s1_en;
   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

   // Stage 1: quotient by 10000 through reciprocal multiply
   always_comb begin
      prod_10k    = Prod10kW'(in_date) * Prod10kW'(RECIP_10K);
      s1_quot_in  = prod_10k[Shift10k +: QuotW];
      s1_valid_in = s1_en ? in_valid : s1_valid_ff;
   end

   // Stage 2: year remainder and day quotient by 100
   always_comb begin
      quot_x10k   = 28'(s1_quot_ff) * 28'(DaysPer10k);
      s2_year_in  = YearW'(28'(s1_date_ff) - quot_x10k);
      prod_day    = Prod100W'(s1_quot_ff) * Prod100W'(RECIP_100);
      s2_day_in   = prod_day[Shift100 +: DayW];
      s2_zero_in  = (s1_date_ff == '0);
      s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
   end

   // Stage 3: month remainder, century quotients and 365-day year term
   always_comb begin
      day_x100       = (QuotW+1)'(s2_day_ff) * (QuotW+1)'(100);
      y_s3           = s2_year_ff - YearW'(1);
      prod_cent_y    = Prod100W'(y_s3) * Prod100W'(RECIP_100);
      prod_cent_year = Prod100W'(s2_year_ff) * Prod100W'(RECIP_100);
      s3_data_in.zero      = s2_zero_ff;
      s3_data_in.year_zero = (s2_year_ff == '0);
      s3_data_in.month     = MonthW'((QuotW+1)'(s2_quot_ff) - day_x100);
      s3_data_in.day       = s2_day_ff;
      s3_data_in.y         = y_s3;
      s3_data_in.cent_y    = prod_cent_y[Shift100 +: CentW];
      s3_data_in.cent_year = prod_cent_year[Shift100 +: CentW];
      s3_data_in.y365      = CountW'(y_s3) * CountW'(DaysPerYear);
      s3_valid_in          = s3_en ? s2_valid_ff : s3_valid_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_date_ff <= in_date;
         s1_quot_ff <= s1_quot_in;
      end
      if (s2_en) begin
         s2_zero_ff <= s2_zero_in;
         s2_year_ff <= s2_year_in;
         s2_quot_ff <= s1_quot_ff;
         s2_day_ff  <= s2_day_in;
      end
      if (s3_en) begin
         s3_data_ff <= s3_data_in;
      end
   end

endmodule

// ----- rtl/dtdc_count.sv -----
// Two-stage check and day-count sum: leap rule, error priority, year and month terms.
// Depends on dtdc_pkg. Instantiated by date_to_day_count.
module dtdc_count (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  dtdc_pkg::dtdc_split_type    in_data,
   output logic                        out_valid,
   input  logic                        out_stall,
   output logic [dtdc_pkg::CountW-1:0] out_count,
   output logic [dtdc_pkg::ErrW-1:0]   out_err
);
   import dtdc_pkg::*;

   // Stage 4 registers
   logic                 s4_valid_ff, s4_valid_in;
   logic [ErrW-1:0]      s4_err_ff, s4_err_in;
   logic [CountW-1:0]    s4_years_ff, s4_years_in;
   logic [MdayW-1:0]     s4_mdays_ff, s4_mdays_in;
   // Output registers
   logic                 s5_valid_ff, s5_valid_in;
   logic [CountW-1:0]    s5_count_ff, s5_count_in;
   logic [ErrW-1:0]      s5_err_ff;

   logic                 s4_en, s5_en;
   logic                 leap;
   logic [4:0]           mlen;

   assign s5_en     = !s5_valid_ff || !out_stall;
   assign s4_en     = !s4_valid_ff || s5_en;
   assign in_stall  = !s4_en;
   assign out_valid = s5_valid_ff;
   assign out_count = s5_count_ff;
   assign out_err   = s5_err_ff;

   // Stage 4: leap rule from century quotients, checks, partial sums
   always_comb begin
      // year divisible by 100 exactly when year/100 differs from (year-1)/100
      leap = ((in_data.y[1:0] == 2'b11) && (in_data.cent_y == in_data.cent_year))
             || (in_data.cent_y[CentW-1:2] != in_data.cent_year[CentW-1:2]);
      mlen = month_len_fn(in_data.month, leap);
      priority if (in_data.zero)
         s4_err_in = ERR_ZERO;
      else if (in_data.year_zero)
         s4_err_in = ERR_YEAR;
      else if ((in_data.month < MonthW'(1)) || (in_data.month > MonthW'(MonthsMax)))
         s4_err_in = ERR_MONTH;
      else if ((in_data.day < DayW'(1)) || (in_data.day > DayW'(mlen)))
         s4_err_in = ERR_DAY;
      else
         s4_err_in = ERR_OK;
      s4_years_in = in_data.y365 + CountW'(in_data.y[YearW-1:2])
                    - CountW'(in_data.cent_y) + CountW'(in_data.cent_y[CentW-1:2]);
      s4_mdays_in = MdayW'(days_before_fn(in_data.month))
                    + MdayW'(leap && (in_data.month > MonthW'(2)))
                    + MdayW'(in_data.day);
      s4_valid_in = s4_en ? in_valid : s4_valid_ff;
   end

   // Stage 5: final sum, forced to zero on error
   always_comb begin
      s5_count_in = (s4_err_ff == ERR_OK) ? (s4_years_ff + CountW'(s4_mdays_ff)) : '0;
      s5_valid_in = s5_en ? s4_valid_ff : s5_valid_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_err_ff   <= s4_err_in;
         s4_years_ff <= s4_years_in;
         s4_mdays_ff <= s4_mdays_in;
      end
      if (s5_en) begin
         s5_count_ff <= s5_count_in;
         s5_err_ff   <= s4_err_ff;
      end
   end

endmodule

// ----- rtl/date_to_day_count.sv -----
// Top level: packed ddmmyyyy date to Gregorian day number, five-stage pipeline.
// Depends on dtdc_pkg, dtdc_split and dtdc_count.
//
//   channel  dir  ports                                                transfer when
//   req      in   req_valid, req_stall, req_packed_date                req_valid && !req_stall
//   rsp      out  rsp_valid, rsp_stall, rsp_day_count, rsp_error_code  rsp_valid && !rsp_stall
//
// Five register stages; one date may transfer every cycle while the response is not
// stalled. The depth is set by the two reciprocal multiplies of the decimal split,
// the century and 365-day products, the checks and the final sum.
// Reset clears all valid bits. Each stage holds while its successor is full and
// stalled, so a bubble is filled even when the response is stalled.
module date_to_day_count (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dtdc_pkg::DateW-1:0]   req_packed_date,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dtdc_pkg::CountW-1:0]  rsp_day_count,
   output logic [dtdc_pkg::ErrW-1:0]    rsp_error_code
);
   import dtdc_pkg::*;

   logic           mid_valid;
   logic           mid_stall;
   dtdc_split_type mid_data;

   // Decimal split stages
   dtdc_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_date   (req_packed_date),
      .out_valid (mid_valid),
      .out_stall (mid_stall),
      .out_data  (mid_data)
   );

   // Check and sum stages
   dtdc_count u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_stall  (mid_stall),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_count (rsp_day_count),
      .out_err   (rsp_error_code)
   );

endmodule
